@@ rtl/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, codes and the byte classifier of the character class tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  // result kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_ERROR = 2'd1;
  localparam logic [1:0] RK_END   = 2'd2;

  // token types
  localparam logic [3:0] TY_WORD     = 4'd0;
  localparam logic [3:0] TY_NUMBER   = 4'd1;
  localparam logic [3:0] TY_STRING   = 4'd2;
  localparam logic [3:0] TY_COLON    = 4'd3;
  localparam logic [3:0] TY_DOT      = 4'd4;
  localparam logic [3:0] TY_COMMA    = 4'd5;
  localparam logic [3:0] TY_PERCENT  = 4'd6;
  localparam logic [3:0] TY_EXCLAM   = 4'd7;
  localparam logic [3:0] TY_QUESTION = 4'd8;
  localparam logic [3:0] TY_HASH     = 4'd9;
  localparam logic [3:0] TY_AT       = 4'd10;
  localparam logic [3:0] TY_PLUS     = 4'd11;
  localparam logic [3:0] TY_MINUS    = 4'd12;
  localparam logic [3:0] TY_EQUALS   = 4'd13;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [2:0] {
    CL_BAD   = 3'd0,
    CL_SPACE = 3'd1,
    CL_QUOTE = 3'd2,
    CL_ESC   = 3'd3,
    CL_WORD  = 3'd4,
    CL_DIGIT = 3'd5,
    CL_PUNCT = 3'd6
  } char_class_t;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_WORD   = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_ESCAPE = 6'b010000,
    MODE_DRAIN  = 6'b100000
  } lex_mode_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  ptype;
  } class_info_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  token_type;
    logic [15:0] position;
    logic [7:0]  token_length;
    logic        end_status;
    logic        last_of_run;
  } result_t;

  function automatic class_info_t classify(input logic [7:0] c);
    class_info_t info;
    info.cls   = CL_BAD;
    info.ptype = TY_WORD;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0d || c == 8'h0c) begin
      info.cls = CL_SPACE;
    end else if (c == 8'h22) begin
      info.cls = CL_QUOTE;
    end else if (c == 8'h5c) begin
      info.cls = CL_ESC;
    end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f) begin
      info.cls = CL_WORD;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      info.cls = CL_DIGIT;
    end else begin
      info.cls = CL_PUNCT;
      unique case (c)
        8'h3a:   info.ptype = TY_COLON;
        8'h2e:   info.ptype = TY_DOT;
        8'h2c:   info.ptype = TY_COMMA;
        8'h25:   info.ptype = TY_PERCENT;
        8'h21:   info.ptype = TY_EXCLAM;
        8'h3f:   info.ptype = TY_QUESTION;
        8'h23:   info.ptype = TY_HASH;
        8'h40:   info.ptype = TY_AT;
        8'h2b:   info.ptype = TY_PLUS;
        8'h2d:   info.ptype = TY_MINUS;
        8'h3d:   info.ptype = TY_EQUALS;
        default: info.cls = CL_BAD;
      endcase
    end
    return info;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cct_if.sv @@
// ----------------------------------------------------------------------------
// cct_if
// Valid/ready channels for text bytes in and tokenizer results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;

  modport source (output valid, kind, ch, input ready);
  modport sink   (input valid, kind, ch, output ready);
endinterface

interface cct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  token_type;
  logic [15:0] position;
  logic [7:0]  token_length;
  logic        end_status;
  logic        last_of_run;

  modport source (output valid, result_kind, token_type, position, token_length,
                  end_status, last_of_run, input ready);
  modport sink   (input valid, result_kind, token_type, position, token_length,
                  end_status, last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/cct_result_queue.sv @@
// ----------------------------------------------------------------------------
// cct_result_queue
// Small result queue that takes up to two items per cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_result_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_count,
  input  wire cct_pkg::result_t  push_first,
  input  wire cct_pkg::result_t  push_second,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cct_pkg::result_t       out_item
);

  localparam int AW = cct_pkg::QUEUE_AW;

  cct_pkg::result_t entries [cct_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_item  = entries[rptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (AW+1)'(cct_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wptr + AW'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(push_count);
      rptr  <= rptr + AW'(pop);
      count <= count + (AW+1)'(push_count) - (AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/char_class_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// char_class_tokenizer_core
// Byte-serial tokenizer: words, numbers, strings, punctuation and errors.
// ----------------------------------------------------------------------------
// Takes one text byte or end-of-text item per cycle and returns tokens, errors
// and a final end result carrying the error status. Each item gives zero, one
// or two results; the lexer state updates in the cycle the item is accepted and
// its results go into a four-entry queue, so the result port shows them from
// the next cycle on. Items are taken every cycle while the queue has room for
// two results; with the result port never stalled, the sustained rate is one item
// per cycle, bounded only by the one-result-per-cycle output port when items give two results.
`default_nettype none

module char_class_tokenizer_core #(
  parameter int NAME_LIMIT  = 64,
  parameter int OFFSET_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cct_in_if.sink     text,
  cct_out_if.source  result
);

  localparam int RW = $clog2(NAME_LIMIT + 1);

  cct_pkg::lex_mode_t     mode, mode_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic                   error_seen, error_seen_next;
  logic [RW-1:0]          run_len, run_len_next;

  logic                   accept;
  logic                   room;
  logic [1:0]             push_count;
  cct_pkg::result_t       res [2];
  cct_pkg::result_t       head;
  cct_pkg::class_info_t   info;

  function automatic logic [15:0] pos16(input logic [OFFSET_BITS-1:0] off);
    logic [31:0] wide;
    wide = 32'(off);
    return wide[15:0];
  endfunction

  function automatic cct_pkg::result_t make_result(input logic [1:0] rk,
                                                   input logic [3:0] ty,
                                                   input logic [15:0] pos,
                                                   input logic [7:0] len,
                                                   input logic st);
    cct_pkg::result_t r;
    r.result_kind  = rk;
    r.token_type   = ty;
    r.position     = pos;
    r.token_length = len;
    r.end_status   = st;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign accept     = text.valid && text.ready;
  assign text.ready = room;
  assign info       = cct_pkg::classify(text.ch);

  always_comb begin
    logic [1:0]  n;
    logic        fresh;
    logic [7:0]  str_len;
    logic [RW-1:0] run_bump;
    mode_next          = mode;
    pending_start_next = pending_start;
    byte_offset_next   = byte_offset;
    error_seen_next    = error_seen;
    run_len_next       = run_len;
    res[0]             = '0;
    res[1]             = '0;
    n                  = 2'd0;
    fresh              = 1'b0;
    run_bump = (run_len < RW'(NAME_LIMIT)) ? run_len + RW'(1) : run_len;
    str_len  = (run_len >= RW'(NAME_LIMIT - 2)) ? 8'(NAME_LIMIT - 2) : 8'(run_len);

    if (accept) begin
      if (text.kind == cct_pkg::KIND_END) begin
        if (mode == cct_pkg::MODE_WORD) begin
          res[0] = make_result(cct_pkg::RK_TOKEN, cct_pkg::TY_WORD, pos16(pending_start),
                               8'(run_len), 1'b0);
          n = 2'd1;
        end else if (mode == cct_pkg::MODE_NUMBER) begin
          res[0] = make_result(cct_pkg::RK_TOKEN, cct_pkg::TY_NUMBER, pos16(pending_start),
                               8'd1, 1'b0);
          n = 2'd1;
        end else if (mode == cct_pkg::MODE_STRING || mode == cct_pkg::MODE_ESCAPE) begin
          res[0] = make_result(cct_pkg::RK_ERROR, cct_pkg::TY_WORD, pos16(pending_start),
                               8'd0, 1'b0);
          n = 2'd1;
        end
        res[n[0]] = make_result(cct_pkg::RK_END, cct_pkg::TY_WORD, pos16(byte_offset), 8'd0,
                                error_seen || mode == cct_pkg::MODE_STRING ||
                                mode == cct_pkg::MODE_ESCAPE);
        n                  = n + 2'd1;
        mode_next          = cct_pkg::MODE_IDLE;
        pending_start_next = '0;
        byte_offset_next   = '0;
        error_seen_next    = 1'b0;
        run_len_next       = '0;
      end else begin
        byte_offset_next = byte_offset + OFFSET_BITS'(1);
        unique case (mode)
          cct_pkg::MODE_DRAIN: begin
          end
          cct_pkg::MODE_STRING: begin
            if (info.cls == cct_pkg::CL_QUOTE) begin
              res[0] = make_result(cct_pkg::RK_TOKEN, cct_pkg::TY_STRING, pos16(pending_start),
                                   str_len, 1'b0);
              n = 2'd1;
              mode_next = cct_pkg::MODE_IDLE;
            end else begin
              if (info.cls == cct_pkg::CL_ESC) begin
                mode_next = cct_pkg::MODE_ESCAPE;
              end
              run_len_next = run_bump;
            end
          end
          cct_pkg::MODE_ESCAPE: begin
            if (info.cls == cct_pkg::CL_QUOTE) begin
              run_len_next = run_bump;
              mode_next    = cct_pkg::MODE_STRING;
            end else begin
              res[0] = make_result(cct_pkg::RK_ERROR, cct_pkg::TY_WORD, pos16(byte_offset),
                                   8'd0, 1'b0);
              n = 2'd1;
              mode_next       = cct_pkg::MODE_DRAIN;
              error_seen_next = 1'b1;
            end
          end
          cct_pkg::MODE_WORD: begin
            if (info.cls == cct_pkg::CL_WORD || info.cls == cct_pkg::CL_DIGIT) begin
              if (run_len >= RW'(NAME_LIMIT)) begin
                res[0] = make_result(cct_pkg::RK_ERROR, cct_pkg::TY_WORD, pos16(byte_offset),
                                     8'd0, 1'b0);
                n = 2'd1;
                mode_next       = cct_pkg::MODE_DRAIN;
                error_seen_next = 1'b1;
              end else begin
                run_len_next = run_bump;
              end
            end else begin
              res[0] = make_result(cct_pkg::RK_TOKEN, cct_pkg::TY_WORD, pos16(pending_start),
                                   8'(run_len), 1'b0);
              n = 2'd1;
              fresh = 1'b1;
            end
          end
          cct_pkg::MODE_NUMBER: begin
            if (info.cls != cct_pkg::CL_DIGIT) begin
              res[0] = make_result(cct_pkg::RK_TOKEN, cct_pkg::TY_NUMBER, pos16(pending_start),
                                   8'd1, 1'b0);
              n = 2'd1;
              fresh = 1'b1;
            end
          end
          default: begin
            fresh = 1'b1;
          end
        endcase

        if (fresh) begin
          mode_next = cct_pkg::MODE_IDLE;
          unique case (info.cls)
            cct_pkg::CL_SPACE: begin
            end
            cct_pkg::CL_QUOTE: begin
              pending_start_next = byte_offset;
              mode_next          = cct_pkg::MODE_STRING;
              run_len_next       = '0;
            end
            cct_pkg::CL_WORD: begin
              pending_start_next = byte_offset;
              mode_next          = cct_pkg::MODE_WORD;
              run_len_next       = RW'(1);
            end
            cct_pkg::CL_DIGIT: begin
              pending_start_next = byte_offset;
              mode_next          = cct_pkg::MODE_NUMBER;
              run_len_next       = RW'(1);
            end
            cct_pkg::CL_PUNCT: begin
              res[n[0]] = make_result(cct_pkg::RK_TOKEN, info.ptype, pos16(byte_offset),
                                      8'd1, 1'b0);
              n = n + 2'd1;
            end
            default: begin
              res[n[0]] = make_result(cct_pkg::RK_ERROR, cct_pkg::TY_WORD, pos16(byte_offset),
                                      8'd0, 1'b0);
              n = n + 2'd1;
              mode_next       = cct_pkg::MODE_DRAIN;
              error_seen_next = 1'b1;
            end
          endcase
        end
      end
    end

    if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end
    push_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= cct_pkg::MODE_IDLE;
      pending_start <= '0;
      byte_offset   <= '0;
      error_seen    <= 1'b0;
      run_len       <= '0;
    end else begin
      mode          <= mode_next;
      pending_start <= pending_start_next;
      byte_offset   <= byte_offset_next;
      error_seen    <= error_seen_next;
      run_len       <= run_len_next;
    end
  end

  cct_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (res[0]),
    .push_second (res[1]),
    .room        (room),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_item    (head)
  );

  assign result.result_kind  = head.result_kind;
  assign result.token_type   = head.token_type;
  assign result.position     = head.position;
  assign result.token_length = head.token_length;
  assign result.end_status   = head.end_status;
  assign result.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

@@ bench/tokenizer_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tokenizer_check_pkg
// Token tracker for the tokenizer bench: follows the scan of each text byte,
// queues the tokens, errors and end results the core owes, and checks each
// result leaving the core against the oldest one still owed.
// ----------------------------------------------------------------------------
package tokenizer_check_pkg;

  localparam int          NAME_MAX  = 64;
  localparam int          POS_BITS  = 16;
  localparam logic [7:0]  QUOTE_CH  = 8'h22;
  localparam logic [7:0]  BSLASH_CH = 8'h5c;
  localparam logic [3:0]  NO_TYPE   = 4'd0;

  typedef enum {
    SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_STRING, SCAN_ESCAPE, SCAN_DRAIN
  } scan_state_t;

  typedef enum {
    BC_BAD, BC_SPACE, BC_QUOTE, BC_ESC, BC_WORD, BC_DIGIT, BC_PUNCT
  } byte_class_t;

  class token_tracker;
    scan_state_t          scan;
    logic [3:0]           held_type;
    logic [15:0]          held_start;
    logic [15:0]          text_pos;
    bit                   fault_seen;
    int unsigned          held_len;
    cct_pkg::result_t     due_results[$];
    int unsigned          mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      scan       = SCAN_IDLE;
      held_type  = cct_pkg::TY_WORD;
      held_start = '0;
      text_pos   = '0;
      fault_seen = 1'b0;
      held_len   = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void add(logic [1:0] rk, logic [3:0] ty, logic [15:0] pos, logic [7:0] len,
                      bit status);
      cct_pkg::result_t r;
      r.result_kind  = rk;
      r.token_type   = ty;
      r.position     = pos;
      r.token_length = len;
      r.end_status   = status;
      r.last_of_run  = 1'b0;
      due_results.push_back(r);
    endfunction

    function void fail_at(logic [15:0] pos);
      add(cct_pkg::RK_ERROR, NO_TYPE, pos, 8'd0, 1'b0);
      scan       = SCAN_DRAIN;
      fault_seen = 1'b1;
    endfunction

    function void bump();
      if (held_len < 32'hffff) held_len++;
    endfunction

    // strings report the raw byte count between the quotes, capped so that
    // the token with its quotes stays within the name limit
    function logic [7:0] held_length();
      int unsigned full;
      if (held_type == cct_pkg::TY_WORD) begin
        return (held_len < NAME_MAX) ? 8'(held_len) : 8'(NAME_MAX);
      end
      if (held_type == cct_pkg::TY_STRING) begin
        full = held_len + 2;
        if (full > NAME_MAX) full = NAME_MAX;
        return 8'(full - 2);
      end
      return 8'd1;
    endfunction

    function byte_class_t sort_byte(logic [7:0] c, output logic [3:0] ptype);
      ptype = NO_TYPE;
      case (c)
        8'h20, 8'h09, 8'h0b, 8'h0d, 8'h0c: return BC_SPACE;
        QUOTE_CH:  return BC_QUOTE;
        BSLASH_CH: return BC_ESC;
        "_":       return BC_WORD;
        ":": begin ptype = cct_pkg::TY_COLON;    return BC_PUNCT; end
        ".": begin ptype = cct_pkg::TY_DOT;      return BC_PUNCT; end
        ",": begin ptype = cct_pkg::TY_COMMA;    return BC_PUNCT; end
        "%": begin ptype = cct_pkg::TY_PERCENT;  return BC_PUNCT; end
        "!": begin ptype = cct_pkg::TY_EXCLAM;   return BC_PUNCT; end
        "?": begin ptype = cct_pkg::TY_QUESTION; return BC_PUNCT; end
        "#": begin ptype = cct_pkg::TY_HASH;     return BC_PUNCT; end
        "@": begin ptype = cct_pkg::TY_AT;       return BC_PUNCT; end
        "+": begin ptype = cct_pkg::TY_PLUS;     return BC_PUNCT; end
        "-": begin ptype = cct_pkg::TY_MINUS;    return BC_PUNCT; end
        "=": begin ptype = cct_pkg::TY_EQUALS;   return BC_PUNCT; end
        default: ;
      endcase
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return BC_WORD;
      if (c >= "0" && c <= "9") return BC_DIGIT;
      return BC_BAD;
    endfunction

    // returns 0 for a byte dropped after an error
    function bit expect_results(logic kind, logic [7:0] ch);
      byte_class_t      cls;
      logic [3:0]       ptype;
      logic [15:0]      pos;
      bit               fresh;
      bit               live;
      int               before_n;
      cct_pkg::result_t tail;
      before_n = due_results.size();
      live     = (kind == cct_pkg::KIND_END) || (scan != SCAN_DRAIN);
      fresh    = 1'b0;
      if (kind == cct_pkg::KIND_END) begin
        if (scan == SCAN_WORD || scan == SCAN_NUMBER) begin
          add(cct_pkg::RK_TOKEN, held_type, held_start, held_length(), 1'b0);
        end else if (scan == SCAN_STRING || scan == SCAN_ESCAPE) begin
          add(cct_pkg::RK_ERROR, NO_TYPE, held_start, 8'd0, 1'b0);
          fault_seen = 1'b1;
        end
        add(cct_pkg::RK_END, NO_TYPE, text_pos, 8'd0, fault_seen);
        restart();
      end else begin
        cls      = sort_byte(ch, ptype);
        pos      = text_pos;
        text_pos = text_pos + 16'd1;
        case (scan)
          SCAN_DRAIN: ;
          SCAN_STRING: begin
            if (cls == BC_QUOTE) begin
              add(cct_pkg::RK_TOKEN, cct_pkg::TY_STRING, held_start, held_length(), 1'b0);
              scan = SCAN_IDLE;
            end else begin
              if (cls == BC_ESC) scan = SCAN_ESCAPE;
              bump();
            end
          end
          SCAN_ESCAPE: begin
            if (cls == BC_QUOTE) begin
              bump();
              scan = SCAN_STRING;
            end else begin
              fail_at(pos);
            end
          end
          SCAN_WORD: begin
            if (cls == BC_WORD || cls == BC_DIGIT) begin
              if (held_len >= NAME_MAX) fail_at(pos);
              else bump();
            end else begin
              add(cct_pkg::RK_TOKEN, cct_pkg::TY_WORD, held_start, held_length(), 1'b0);
              fresh = 1'b1;
            end
          end
          SCAN_NUMBER: begin
            if (cls != BC_DIGIT) begin
              add(cct_pkg::RK_TOKEN, cct_pkg::TY_NUMBER, held_start, 8'd1, 1'b0);
              fresh = 1'b1;
            end
          end
          default: fresh = 1'b1;
        endcase
        if (fresh) begin
          scan = SCAN_IDLE;
          case (cls)
            BC_SPACE: ;
            BC_QUOTE: begin
              held_start = pos;
              held_type  = cct_pkg::TY_STRING;
              held_len   = 0;
              scan       = SCAN_STRING;
            end
            BC_WORD: begin
              held_start = pos;
              held_type  = cct_pkg::TY_WORD;
              held_len   = 1;
              scan       = SCAN_WORD;
            end
            BC_DIGIT: begin
              held_start = pos;
              held_type  = cct_pkg::TY_NUMBER;
              held_len   = 1;
              scan       = SCAN_NUMBER;
            end
            BC_PUNCT: add(cct_pkg::RK_TOKEN, ptype, pos, 8'd1, 1'b0);
            default:  fail_at(pos);
          endcase
        end
      end
      if (due_results.size() > before_n) begin
        tail = due_results.pop_back();
        tail.last_of_run = 1'b1;
        due_results.push_back(tail);
      end
      return live;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got_v);
      if (want !== got_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got_v);
      end
    endfunction

    function void check_result(cct_pkg::result_t got);
      cct_pkg::result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got kind %0d type %0d pos %0d len %0d",
                 $time, got.result_kind, got.token_type, got.position, got.token_length);
        return;
      end
      want = due_results.pop_front();
      compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      compare_field("token_type", 16'(want.token_type), 16'(got.token_type));
      compare_field("position", want.position, got.position);
      compare_field("token_length", 16'(want.token_length), 16'(got.token_length));
      compare_field("end_status", 16'(want.end_status), 16'(got.end_status));
      compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the character class tokenizer core: a short directed text covers
// every token type and every error case but the overlong word, then random
// sentences of mostly well-formed tokens with some noise are fed with random gaps
// and output stalls, and every result is checked against the token tracker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIVE_ITEMS = 1300;

  localparam logic [7:0] PUNCT_SET [11] = '{":", ".", ",", "%", "!", "?", "#", "@", "+", "-", "="};
  localparam logic [7:0] SPACE_SET [5]  = '{8'h20, 8'h09, 8'h0b, 8'h0d, 8'h0c};

  logic clk;
  logic rst;
  bit   calm;
  int   live_items;
  int   sentence;

  tokenizer_check_pkg::token_tracker tracker;
  cct_pkg::result_t                  seen;

  cct_in_if  text_ch ();
  cct_out_if result_ch ();

  char_class_tokenizer_core #(
    .NAME_LIMIT (tokenizer_check_pkg::NAME_MAX),
    .OFFSET_BITS(tokenizer_check_pkg::POS_BITS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .result(result_ch)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen.result_kind  = result_ch.result_kind;
      seen.token_type   = result_ch.token_type;
      seen.position     = result_ch.position;
      seen.token_length = result_ch.token_length;
      seen.end_status   = result_ch.end_status;
      seen.last_of_run  = result_ch.last_of_run;
      tracker.check_result(seen);
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] ch);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 11) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.kind  <= kind;
    text_ch.ch    <= ch;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    if (tracker.expect_results(kind, ch)) live_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(cct_pkg::KIND_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_byte(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] string_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == tokenizer_check_pkg::QUOTE_CH || b == tokenizer_check_pkg::BSLASH_CH);
    return b;
  endfunction

  task automatic random_sentence();
    int count;
    int sel;
    int len;
    count = $urandom_range(1, 10);
    for (int t = 0; t < count; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 8);
        send_item(cct_pkg::KIND_BYTE, word_byte(1'b1));
        for (int k = 1; k < len; k++) send_item(cct_pkg::KIND_BYTE, word_byte(1'b0));
      end else if (sel < 42) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          send_item(cct_pkg::KIND_BYTE, 8'("0" + $urandom_range(0, 9)));
        end
      end else if (sel < 56) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 6);
        send_item(cct_pkg::KIND_BYTE, tokenizer_check_pkg::QUOTE_CH);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(cct_pkg::KIND_BYTE, tokenizer_check_pkg::BSLASH_CH);
            send_item(cct_pkg::KIND_BYTE, ($urandom_range(0, 7) == 0) ?
                      string_byte() : tokenizer_check_pkg::QUOTE_CH);
          end else begin
            send_item(cct_pkg::KIND_BYTE, string_byte());
          end
        end
        // unterminated string runs into the end of text
        if ($urandom_range(0, 24) == 0) break;
        send_item(cct_pkg::KIND_BYTE, tokenizer_check_pkg::QUOTE_CH);
      end else if (sel < 76) begin
        send_item(cct_pkg::KIND_BYTE, PUNCT_SET[$urandom_range(0, 10)]);
      end else if (sel < 95) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          send_item(cct_pkg::KIND_BYTE, SPACE_SET[$urandom_range(0, 4)]);
        end
      end else begin
        send_item(cct_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) == 0) begin
        send_item(cct_pkg::KIND_BYTE, SPACE_SET[$urandom_range(0, 4)]);
      end
    end
    send_item(cct_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    tracker = new();
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    live_items = 0;
    text_ch.valid = 1'b0;
    text_ch.kind = cct_pkg::KIND_BYTE;
    text_ch.ch = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every token type, escaped quote, then each error path but the overlong word
    send_text("a_Z9:.,%!?#@+-=7\t\"\\\"\"");
    send_item(cct_pkg::KIND_END, 8'hff);
    send_item(cct_pkg::KIND_BYTE, tokenizer_check_pkg::BSLASH_CH);
    send_item(cct_pkg::KIND_END, 8'h00);
    send_text("\"\\");
    send_item(cct_pkg::KIND_BYTE, 8'hff);
    send_item(cct_pkg::KIND_END, 8'h00);
    send_item(cct_pkg::KIND_BYTE, 8'h0a);
    send_item(cct_pkg::KIND_END, 8'h00);
    send_item(cct_pkg::KIND_BYTE, tokenizer_check_pkg::QUOTE_CH);
    send_item(cct_pkg::KIND_END, 8'h00);
    wait_drained();

    sentence = 0;
    while (live_items < LIVE_ITEMS) begin
      calm = (sentence >= 25 && sentence < 40);
      if (sentence == 60) wait_drained();
      random_sentence();
      sentence++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("** char_class_tokenizer_core: PASSED **");
    end else begin
      $display("** char_class_tokenizer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** char_class_tokenizer_core: FAILED **");
    $finish;
  end

endmodule

@@ char_class_tokenizer_core.f @@
rtl/cct_pkg.sv
rtl/cct_if.sv
rtl/cct_result_queue.sv
rtl/char_class_tokenizer_core.sv
bench/tokenizer_check_pkg.sv
bench/tb_top.sv
